/* rtl/core/console_token_recognizer_defines.svh */
// Assertion helpers for the RTL of the token recognizer.
`ifndef CONSOLE_TOKEN_RECOGNIZER_DEFINES_SVH
`define CONSOLE_TOKEN_RECOGNIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/ctr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ctr_pkg;

    localparam int CTR_CELL_BITS = 16;

    localparam logic [15:0] HASH_SEED   = 16'd5381;
    localparam logic [15:0] HASH_FACTOR = 16'd33;
    localparam logic [5:0]  COUNT_MAX   = 6'd63;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;
    localparam logic [7:0] CHAR_LZ     = 8'h7A;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // bit positions in the validity and overflow flag words
    localparam int VF_DEC  = 0;
    localparam int VF_HEX  = 1;
    localparam int VF_EVEN = 2;
    localparam int OF_DEC  = 0;
    localparam int OF_HEX  = 1;

    typedef enum logic [2:0] {
        LEAD_NONE,
        LEAD_PLAIN,
        LEAD_HEX,
        LEAD_STR,
        LEAD_HEXSTR
    } t_lead;

    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_MINUS,
        SIGN_PLUS
    } t_sign;

    typedef enum logic [2:0] {
        CLS_DEC,
        CLS_HEX,
        CLS_STR,
        CLS_HEXSTR,
        CLS_WORD,
        CLS_OVF,
        CLS_EMPTY
    } t_class;

    typedef struct packed {
        logic        empty_line;
        logic        line_end;
        logic [15:0] hash;
        t_sign       sign;
        logic [5:0]  char_count;
        t_lead       lead;
        logic [2:0]  valid;
        logic [1:0]  ovf;
        logic [5:0]  pair_count;
    } t_word_info;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // {ok, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ctr_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ctr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ctr_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_class;
    logic [15:0] token_value;
    logic [15:0] word_hash;
    logic        line_end;

    modport source (output valid, output token_class, output token_value,
                    output word_hash, output line_end, input ready);
    modport sink   (input valid, input token_class, input token_value,
                    input word_hash, input line_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/ctr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctr_front #(
    parameter int CELL_BITS = ctr_pkg::CTR_CELL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ctr_char_if.sink              i_char,
    input  ctr_pkg::t_q_status    i_q_status,
    output logic                  o_push,
    output ctr_pkg::t_word_info   o_info,
    output logic [CELL_BITS-1:0]  o_dec,
    output logic [CELL_BITS-1:0]  o_hex
);
    import ctr_pkg::*;

    localparam int AW = CELL_BITS + 4;

    logic [15:0]          r_hash, n_hash;
    logic [CELL_BITS-1:0] r_dec, n_dec;
    logic [CELL_BITS-1:0] r_hex, n_hex;
    t_sign                r_sign, n_sign;
    logic [5:0]           r_cc, n_cc;
    t_lead                r_lead, n_lead;
    logic [2:0]           r_valid, n_valid;
    logic [1:0]           r_ovf, n_ovf;
    logic [5:0]           r_pairs, n_pairs;

    logic [7:0]    c;
    logic [7:0]    folded;
    logic          accept, is_cr, is_blank, is_print, take, sign_char;
    logic [AW-1:0] dec_ext;
    logic [4:0]    hex_dig;

    assign c        = i_char.char_code;
    assign accept   = i_char.valid && i_char.ready;
    assign is_cr    = (c == CHAR_CR);
    assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    assign is_print = (c >= CHAR_SPACE) && (c < CHAR_DEL);
    assign take     = accept && !is_cr && !is_blank && is_print;
    assign o_push   = accept && (is_cr || (is_blank && (r_cc != '0)));

    assign i_char.ready = !i_q_status.full;

    assign folded  = (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_OFFSET : c;
    assign dec_ext = ({4'b0, r_dec} << 3) + ({4'b0, r_dec} << 1) + AW'(c[3:0]);
    assign hex_dig = hex_digit(c);

    always_comb begin
        n_hash    = r_hash;
        n_dec     = r_dec;
        n_hex     = r_hex;
        n_sign    = r_sign;
        n_cc      = r_cc;
        n_lead    = r_lead;
        n_valid   = r_valid;
        n_ovf     = r_ovf;
        n_pairs   = r_pairs;
        sign_char = 1'b0;
        if (o_push) begin
            n_hash  = HASH_SEED;
            n_dec   = '0;
            n_hex   = '0;
            n_sign  = SIGN_NONE;
            n_cc    = '0;
            n_lead  = LEAD_NONE;
            n_valid = '1;
            n_ovf   = '0;
            n_pairs = '0;
        end else if (take) begin
            n_hash = 16'(r_hash * HASH_FACTOR) ^ {8'h00, folded};
            if (r_cc == '0) begin
                if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                    n_sign    = (c == CHAR_MINUS) ? SIGN_MINUS : SIGN_PLUS;
                    sign_char = 1'b1;
                    n_lead    = LEAD_PLAIN;
                end else if (c == CHAR_DOLLAR) begin
                    n_lead = LEAD_HEX;
                end else if (c == CHAR_QUOTE) begin
                    n_lead = LEAD_STR;
                end else if (c == CHAR_AMP) begin
                    n_lead = LEAD_HEXSTR;
                end else begin
                    n_lead = LEAD_PLAIN;
                end
            end
            if (!sign_char && r_valid[VF_DEC]) begin
                if (c >= CHAR_0 && c <= CHAR_9) begin
                    // exact test: anything above the cell overflows
                    if (dec_ext[AW-1:CELL_BITS] != '0) begin
                        n_ovf[OF_DEC]   = 1'b1;
                        n_valid[VF_DEC] = 1'b0;
                    end else begin
                        n_dec = dec_ext[CELL_BITS-1:0];
                    end
                end else begin
                    n_valid[VF_DEC] = 1'b0;
                end
            end
            if (r_cc != '0 && (r_lead == LEAD_HEX || r_lead == LEAD_HEXSTR)
                    && r_valid[VF_HEX]) begin
                if (!hex_dig[4]) begin
                    n_valid[VF_HEX] = 1'b0;
                end else if (r_lead == LEAD_HEX) begin
                    if (r_hex[CELL_BITS-1 -: 4] != 4'd0) begin
                        n_ovf[OF_HEX]   = 1'b1;
                        n_valid[VF_HEX] = 1'b0;
                    end else begin
                        n_hex = {r_hex[CELL_BITS-5:0], hex_dig[3:0]};
                    end
                end else begin
                    // count a byte on every second digit
                    n_valid[VF_EVEN] = ~r_valid[VF_EVEN];
                    if (!r_valid[VF_EVEN] && r_pairs != COUNT_MAX) begin
                        n_pairs = r_pairs + 6'd1;
                    end
                end
            end
            if (r_cc != COUNT_MAX) begin
                n_cc = r_cc + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= HASH_SEED;
            r_dec   <= '0;
            r_hex   <= '0;
            r_sign  <= SIGN_NONE;
            r_cc    <= '0;
            r_lead  <= LEAD_NONE;
            r_valid <= '1;
            r_ovf   <= '0;
            r_pairs <= '0;
        end else begin
            r_hash  <= n_hash;
            r_dec   <= n_dec;
            r_hex   <= n_hex;
            r_sign  <= n_sign;
            r_cc    <= n_cc;
            r_lead  <= n_lead;
            r_valid <= n_valid;
            r_ovf   <= n_ovf;
            r_pairs <= n_pairs;
        end
    end

    always_comb begin
        o_info.empty_line = (r_cc == '0);
        o_info.line_end   = is_cr;
        o_info.hash       = r_hash;
        o_info.sign       = r_sign;
        o_info.char_count = r_cc;
        o_info.lead       = r_lead;
        o_info.valid      = r_valid;
        o_info.ovf        = r_ovf;
        o_info.pair_count = r_pairs;
    end

    assign o_dec = r_dec;
    assign o_hex = r_hex;

endmodule

`default_nettype wire

/* rtl/core/ctr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctr_queue #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_head,
    output ctr_pkg::t_q_status o_status
);
    import ctr_pkg::*;

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ctr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctr_back #(
    parameter int CELL_BITS = ctr_pkg::CTR_CELL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctr_pkg::t_q_status   i_q_status,
    input  ctr_pkg::t_word_info  i_info,
    input  logic [CELL_BITS-1:0] i_dec,
    input  logic [CELL_BITS-1:0] i_hex,
    output logic                 o_pop,
    ctr_token_if.source          o_token
);
    import ctr_pkg::*;

    logic                 r_valid;
    t_class               r_class, n_class;
    logic [15:0]          r_value, n_value;
    logic [15:0]          r_hash, n_hash;
    logic                 r_line_end;
    logic [CELL_BITS-1:0] num_val;
    logic                 digits_ok;

    assign o_pop = !i_q_status.empty && (!r_valid || o_token.ready);

    assign digits_ok = (i_info.sign != SIGN_NONE) ? (i_info.char_count >= 6'd2)
                                                  : (i_info.char_count >= 6'd1);

    always_comb begin
        n_class = CLS_WORD;
        num_val = '0;
        n_hash  = i_info.hash;
        if (i_info.empty_line) begin
            n_class = CLS_EMPTY;
            n_hash  = '0;
        end else if (i_info.ovf[OF_DEC]) begin
            n_class = CLS_OVF;
        end else if (i_info.valid[VF_DEC] && digits_ok) begin
            n_class = CLS_DEC;
            num_val = i_dec;
            if (i_info.sign == SIGN_NONE) begin
                if (i_dec[CELL_BITS-1]) begin
                    n_class = CLS_OVF;
                end
            end else if (i_info.sign == SIGN_MINUS) begin
                if (i_dec[CELL_BITS-1] && (i_dec[CELL_BITS-2:0] != '0)) begin
                    n_class = CLS_OVF;
                end else begin
                    num_val = ~i_dec + CELL_BITS'(1);
                end
            end
            if (n_class == CLS_OVF) begin
                num_val = '0;
            end
        end else if (i_info.lead == LEAD_HEX && i_info.ovf[OF_HEX]) begin
            n_class = CLS_OVF;
        end else if (i_info.lead == LEAD_HEX && i_info.valid[VF_HEX]
                && i_info.char_count >= 6'd2) begin
            n_class = CLS_HEX;
            num_val = i_hex;
        end else if (i_info.lead == LEAD_STR) begin
            n_class = CLS_STR;
        end else if (i_info.lead == LEAD_HEXSTR && i_info.valid[VF_HEX]
                && i_info.valid[VF_EVEN]) begin
            n_class = CLS_HEXSTR;
        end
        if (n_class == CLS_HEXSTR) begin
            n_value = 16'(i_info.pair_count);
        end else begin
            n_value = 16'(num_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_token.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_class    <= n_class;
            r_value    <= n_value;
            r_hash     <= n_hash;
            r_line_end <= i_info.line_end;
        end
    end

    assign o_token.valid       = r_valid;
    assign o_token.token_class = r_class;
    assign o_token.token_value = r_value;
    assign o_token.word_hash   = r_hash;
    assign o_token.line_end    = r_line_end;

endmodule

`default_nettype wire

/* rtl/core/console_token_recognizer.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "console_token_recognizer_defines.svh"

// Channel   Dir  Payload                                        Moves when
// i_char    in   char_code[7:0]                                 valid && ready
// o_token   out  token_class[2:0] token_value[15:0]             valid && ready
//                word_hash[15:0] line_end
//
// One character per cycle while the queue has room; a finished word's token
// is pushed into the queue on its ending space, tab or carriage return and
// then moves to the output register. Sustained rate is one transaction per
// cycle unless the output stalls, set by the front end's per-character update.
// Synchronous active-low reset clears the word state, the queue and the
// output valid. A stalled output backs up the two-entry queue; input ready
// drops only when that queue is full.

module console_token_recognizer #(
    parameter int CELL_BITS = ctr_pkg::CTR_CELL_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctr_char_if.sink    i_char,
    ctr_token_if.source o_token
);
    import ctr_pkg::*;

    localparam int QW = $bits(t_word_info) + 2 * CELL_BITS;

    logic                 w_push;
    logic                 w_pop;
    t_q_status            w_q_status;
    t_word_info           w_in_info;
    t_word_info           w_head_info;
    logic [CELL_BITS-1:0] w_in_dec, w_in_hex;
    logic [CELL_BITS-1:0] w_head_dec, w_head_hex;
    logic [QW-1:0]        w_head;

    ctr_front #(.CELL_BITS(CELL_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_char),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_info     (w_in_info),
        .o_dec      (w_in_dec),
        .o_hex      (w_in_hex)
    );

    ctr_queue #(.WIDTH(QW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_in_info, w_in_dec, w_in_hex}),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    assign {w_head_info, w_head_dec, w_head_hex} = w_head;

    ctr_back #(.CELL_BITS(CELL_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_info     (w_head_info),
        .i_dec      (w_head_dec),
        .i_hex      (w_head_hex),
        .o_pop      (w_pop),
        .o_token    (o_token)
    );

    `CTR_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, w_push, !w_q_status.full, "push into full queue")
    `CTR_ASSERT_IMPL(a_pop_data, i_clk, i_rst_n, w_pop, !w_q_status.empty, "pop from empty queue")
    `CTR_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, w_push, !w_q_status.empty, "pushed word lost")
    `CTR_ASSERT_IMPL(a_empty_line, i_clk, i_rst_n, o_token.valid && o_token.token_class == CLS_EMPTY, o_token.line_end && o_token.word_hash == 16'd0, "bad empty line token")

endmodule

`default_nettype wire

/* tb/tb_console_token_recognizer.sv */
`timescale 1ns / 1ps

module tb_console_token_recognizer;
    import ctr_pkg::*;

    localparam int               CELL_BITS    = CTR_CELL_BITS;
    localparam longint unsigned  CELL_UMAX    = (64'd1 << CELL_BITS) - 64'd1;
    localparam longint unsigned  CELL_SMAX    = CELL_UMAX >> 1;
    localparam int               HOLD_CYCLES  = 150;
    localparam int               LIMIT_CYCLES = 400000;

    typedef struct {
        t_class      cls;
        logic [15:0] value;
        logic [15:0] hash;
        logic        line_end;
    } t_token;

    logic i_clk;
    logic i_rst_n;

    ctr_char_if  char_bus ();
    ctr_token_if tok_bus ();

    console_token_recognizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_token (tok_bus)
    );

    // word state of the predictor
    logic [15:0]     w_hash;
    longint unsigned w_dec;
    longint unsigned w_hex;
    t_sign           w_sign;
    logic [5:0]      w_count;
    t_lead           w_lead;
    logic [2:0]      w_valid;
    logic [1:0]      w_ovf;
    logic [5:0]      w_pairs;

    logic [7:0] char_backlog[$];
    t_token     pending_tokens[$];

    int  chars_queued;
    int  chars_sent;
    int  tokens_checked;
    int  class_seen[7];
    int  n_errors;
    int  cycle_count;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  idle_on;
    bit  hold_req;
    bit  char_fire;
    bit  tok_fire;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic clear_word();
        w_hash  = HASH_SEED;
        w_dec   = 0;
        w_hex   = 0;
        w_sign  = SIGN_NONE;
        w_count = '0;
        w_lead  = LEAD_NONE;
        w_valid = 3'b111;
        w_ovf   = 2'b00;
        w_pairs = '0;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
        if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
        if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
        return -1;
    endfunction

    task automatic absorb_char(input logic [7:0] c);
        logic [7:0]      folded;
        logic            first;
        logic            sign_char;
        int              nib;
        longint unsigned d;
        folded = (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_OFFSET : c;
        w_hash = (w_hash * HASH_FACTOR) ^ {8'h00, folded};
        first = (w_count == 0);
        sign_char = 1'b0;
        if (first) begin
            if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                w_sign = (c == CHAR_MINUS) ? SIGN_MINUS : SIGN_PLUS;
                sign_char = 1'b1;
                w_lead = LEAD_PLAIN;
            end else if (c == CHAR_DOLLAR) begin
                w_lead = LEAD_HEX;
            end else if (c == CHAR_QUOTE) begin
                w_lead = LEAD_STR;
            end else if (c == CHAR_AMP) begin
                w_lead = LEAD_HEXSTR;
            end else begin
                w_lead = LEAD_PLAIN;
            end
        end
        if (!sign_char && w_valid[VF_DEC]) begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
                d = longint'(c - CHAR_0);
                // test the exact value against the cell before taking the digit
                if (w_dec > (CELL_UMAX - d) / 10) begin
                    w_ovf[OF_DEC] = 1'b1;
                    w_valid[VF_DEC] = 1'b0;
                end else begin
                    w_dec = w_dec * 10 + d;
                end
            end else begin
                w_valid[VF_DEC] = 1'b0;
            end
        end
        if (!first && (w_lead == LEAD_HEX || w_lead == LEAD_HEXSTR) && w_valid[VF_HEX]) begin
            nib = hex_nibble(c);
            if (nib < 0) begin
                w_valid[VF_HEX] = 1'b0;
            end else if (w_lead == LEAD_HEX) begin
                if (w_hex > (CELL_UMAX >> 4)) begin
                    w_ovf[OF_HEX] = 1'b1;
                    w_valid[VF_HEX] = 1'b0;
                end else begin
                    w_hex = ((w_hex << 4) | longint'(nib)) & CELL_UMAX;
                end
            end else begin
                w_valid[VF_EVEN] = ~w_valid[VF_EVEN];
                if (w_valid[VF_EVEN] && w_pairs < COUNT_MAX) w_pairs++;
            end
        end
        if (w_count < COUNT_MAX) w_count++;
    endtask

    function automatic t_token word_token(input logic le);
        t_token          t;
        longint unsigned val;
        logic [5:0]      min_len;
        t.cls = CLS_WORD;
        val = 0;
        min_len = (w_sign != SIGN_NONE) ? 6'd2 : 6'd1;
        if (w_ovf[OF_DEC]) begin
            t.cls = CLS_OVF;
        end else if (w_valid[VF_DEC] && w_count >= min_len) begin
            t.cls = CLS_DEC;
            val = w_dec;
            if (w_sign == SIGN_NONE) begin
                if (val > CELL_SMAX) t.cls = CLS_OVF;
            end else if (w_sign == SIGN_MINUS) begin
                if (val > CELL_SMAX + 1) t.cls = CLS_OVF;
                else val = (64'd0 - val) & CELL_UMAX;
            end
            if (t.cls == CLS_OVF) val = 0;
        end else if (w_lead == LEAD_HEX && w_ovf[OF_HEX]) begin
            t.cls = CLS_OVF;
        end else if (w_lead == LEAD_HEX && w_valid[VF_HEX] && w_count >= 2) begin
            t.cls = CLS_HEX;
            val = w_hex;
        end else if (w_lead == LEAD_STR) begin
            t.cls = CLS_STR;
        end else if (w_lead == LEAD_HEXSTR && w_valid[VF_EVEN] && w_valid[VF_HEX]) begin
            t.cls = CLS_HEXSTR;
            val = longint'(w_pairs);
        end
        t.value = val[15:0];
        t.hash = w_hash;
        t.line_end = le;
        return t;
    endfunction

    task automatic recognize_char(input logic [7:0] c);
        t_token t;
        if (c == CHAR_CR) begin
            if (w_count > 0) begin
                t = word_token(1'b1);
            end else begin
                t.cls = CLS_EMPTY;
                t.value = '0;
                t.hash = '0;
                t.line_end = 1'b1;
            end
            pending_tokens.push_back(t);
            clear_word();
        end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
            if (w_count > 0) begin
                pending_tokens.push_back(word_token(1'b0));
                clear_word();
            end
        end else if (c > CHAR_SPACE && c < CHAR_DEL) begin
            absorb_char(c);
        end
    endtask

    // stimulus helpers

    task automatic push_char(input logic [7:0] c);
        char_backlog.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char();
        string digs;
        digs = "0123456789abcdefABCDEF";
        return digs[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic add_word();
        logic [7:0]      w[$];
        longint unsigned bounds[10];
        longint unsigned v;
        string           txt;
        int              kind;
        int              n;
        bounds = '{0, 1, 32767, 32768, 32769, 65535, 65536, 65539, 99999, 655350};
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            case ($urandom_range(0, 3))
                2: w.push_back(CHAR_MINUS);
                3: w.push_back(CHAR_PLUS);
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0) v = bounds[$urandom_range(0, 9)];
            else v = $urandom % (10 ** $urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0) w.push_back(CHAR_0);
            txt = $sformatf("%0d", v);
            for (int i = 0; i < txt.len(); i++) w.push_back(txt[i]);
            if ($urandom_range(0, 9) == 0) w.push_back(printable());
        end else if (kind < 45) begin
            w.push_back(CHAR_DOLLAR);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) w.push_back(hex_char());
            if ($urandom_range(0, 9) == 0) w.push_back(printable());
        end else if (kind < 55) begin
            w.push_back(CHAR_QUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) w.push_back(printable());
        end else if (kind < 72) begin
            w.push_back(CHAR_AMP);
            // now and then run the byte count into saturation
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) w.push_back(hex_char());
            if ($urandom_range(0, 7) == 0) w.push_back(printable());
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) w.push_back(printable());
        end
        foreach (w[i]) begin
            if ($urandom_range(0, 24) == 0) push_char(8'($urandom_range(0, 255)));
            push_char(w[i]);
        end
    endtask

    task automatic add_separator();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) begin
            push_char(CHAR_SPACE);
        end else if (r < 16) begin
            push_char(CHAR_TAB);
        end else if (r < 19) begin
            push_char(CHAR_CR);
        end else begin
            push_char(CHAR_SPACE);
            push_char(CHAR_TAB);
            push_char(CHAR_CR);
            push_char(CHAR_CR);
        end
    endtask

    task automatic add_random(input int n);
        int target;
        target = chars_queued + n;
        while (chars_queued < target) begin
            add_word();
            add_separator();
        end
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (char_backlog.size() != 0 || char_bus.valid || pending_tokens.size() != 0);
    endtask

    // character driver

    always @(posedge i_clk) begin : char_accept
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            recognize_char(char_bus.char_code);
            chars_sent++;
        end
        char_fire <= i_rst_n && char_bus.valid && char_bus.ready;
    end

    always @(negedge i_clk) begin : char_driver
        logic       nxt_valid;
        logic [7:0] nxt_code;
        nxt_valid = char_bus.valid;
        nxt_code = char_bus.char_code;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!char_bus.valid || char_fire) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (char_backlog.size() > 0) begin
                nxt_code = char_backlog.pop_front();
                nxt_valid = 1'b1;
                send_gap = idle_on ? $urandom_range(0, 6) : 0;
            end
        end
        char_bus.valid <= nxt_valid;
        char_bus.char_code <= nxt_code;
    end

    // token monitor

    always @(posedge i_clk) begin : token_monitor
        t_token want;
        if (i_rst_n && tok_bus.valid && tok_bus.ready) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected token: class %0d value %0h hash %0h line_end %0b",
                       tok_bus.token_class, tok_bus.token_value, tok_bus.word_hash,
                       tok_bus.line_end);
                n_errors++;
            end else begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                class_seen[want.cls]++;
                if (tok_bus.token_class !== want.cls) begin
                    $error("token_class: expected %0d, actual %0d", want.cls,
                           tok_bus.token_class);
                    n_errors++;
                end
                if (tok_bus.token_value !== want.value) begin
                    $error("token_value: expected %0h, actual %0h", want.value,
                           tok_bus.token_value);
                    n_errors++;
                end
                if (tok_bus.word_hash !== want.hash) begin
                    $error("word_hash: expected %0h, actual %0h", want.hash,
                           tok_bus.word_hash);
                    n_errors++;
                end
                if (tok_bus.line_end !== want.line_end) begin
                    $error("line_end: expected %0b, actual %0b", want.line_end,
                           tok_bus.line_end);
                    n_errors++;
                end
            end
        end
        tok_fire <= i_rst_n && tok_bus.valid && tok_bus.ready;
    end

    always @(negedge i_clk) begin : token_ready
        if (!i_rst_n) begin
            tok_bus.ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (tok_fire) recv_gap = idle_on ? $urandom_range(0, 6) : 0;
            if (hold_left > 0) begin
                hold_left--;
                tok_bus.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                tok_bus.ready <= 1'b0;
            end else begin
                tok_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("console_token_recognizer test failed");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.char_code = '0;
        tok_bus.ready = 1'b0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        clear_word();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty line, blanks, lone sign, lone ampersand, odd hex string,
        // lone dollar, dropped extremes, overflow then junk, most negative
        push_char(CHAR_CR);
        push_char(CHAR_SPACE);
        push_char(CHAR_TAB);
        push_text("- & &abc $ ");
        push_char(8'h00);
        push_char(8'hFF);
        push_text("99999x");
        push_char(CHAR_TAB);
        push_text("-32768");
        push_char(CHAR_CR);
        wait_drain();

        add_random(700);
        wait_drain();

        // hold the output off while characters keep coming
        idle_on = 1'b0;
        hold_req = 1'b1;
        add_random(250);
        wait_drain();

        add_random(300);
        wait_drain();

        idle_on = 1'b1;
        add_random(400);
        wait_drain();

        repeat (20) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            $error("%0d tokens never arrived", pending_tokens.size());
            n_errors++;
        end
        $display("%0d characters accepted, %0d tokens checked", chars_sent, tokens_checked);
        $display("classes: dec %0d hex %0d str %0d hexstr %0d word %0d ovf %0d empty %0d",
                 class_seen[CLS_DEC], class_seen[CLS_HEX], class_seen[CLS_STR],
                 class_seen[CLS_HEXSTR], class_seen[CLS_WORD], class_seen[CLS_OVF],
                 class_seen[CLS_EMPTY]);
        if (n_errors == 0) begin
            $display("console_token_recognizer test passed");
        end else begin
            $display("console_token_recognizer test failed");
        end
        $finish;
    end

endmodule
